@@ hw/rtl/framed_message_stream_parser_top_assert.svh @@
// Assertion macros for the framed message stream parser checker.
// Used by fmsp_checker.sv; needs nothing else.
`ifndef FRAMED_MESSAGE_STREAM_PARSER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_STREAM_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmsp same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmsp next-cycle check failed");

`endif

@@ hw/rtl/fmsp_pkg.sv @@
// Shared types and constants of the framed message stream parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fmsp_pkg;

  localparam int CFG_WIDTH   = 48;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Event kinds on the result channel.
  localparam logic [2:0] EVT_ACK        = 3'd0;
  localparam logic [2:0] EVT_DISCONNECT = 3'd1;
  localparam logic [2:0] EVT_PING       = 3'd2;
  localparam logic [2:0] EVT_SYNC_HDR   = 3'd3;
  localparam logic [2:0] EVT_SYNC_DATA  = 3'd4;
  localparam logic [2:0] EVT_ERROR      = 3'd5;

  // Error codes carried by error events.
  localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
  localparam logic [1:0] ERR_LEN_LONG   = 2'd1;
  localparam logic [1:0] ERR_SYNC_SHORT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_EXP_NAME    = 3'd0;
  localparam logic [2:0] REG_EXP_VERSION = 3'd1;
  localparam logic [2:0] REG_FLAG_MASK   = 3'd2;
  localparam logic [2:0] REG_ACK_CODE    = 3'd3;
  localparam logic [2:0] REG_DISC_CODE   = 3'd4;
  localparam logic [2:0] REG_PING_CODE   = 3'd5;
  localparam logic [2:0] REG_SYNC_CODE   = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [15:0] id;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  err;
  } evt_t;

endpackage

@@ hw/rtl/framed_message_stream_parser_top.sv @@
// Top level of the framed message stream parser: parser, event queue, output stage.
// Depends on fmsp_pkg, fmsp_front, fmsp_queue and fmsp_back.
//
//   Port group   Direction  Handshake           Payload
//   in_*         input      in_valid/in_ready   in_byte
//   out_*        output     out_valid/out_ready event kind, code, id, flags, data, last, error
//   cfg_*        input      cfg_we              cfg_index, cfg_data
//
// One byte is accepted per cycle while the event queue is not full; the parser state
// updates in that same cycle. A result reaches the out_ ports through the four-entry
// event queue and then the output register.
// in_ready falls only while the event queue is full; out_ready low holds the output.
// Reset is synchronous and restores register defaults and an empty queue.
`timescale 1ns / 1ps

module framed_message_stream_parser_top #(
  parameter int NAME_BYTES        = 6,
  parameter int LENGTH_CODE_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_event_kind,
  output logic [7:0]                     out_code_byte,
  output logic [15:0]                    out_message_id,
  output logic [7:0]                     out_sync_flags,
  output logic [7:0]                     out_data_byte,
  output logic                           out_last,
  output logic [1:0]                     out_error_code,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [fmsp_pkg::CFG_WIDTH-1:0] cfg_data
);
  import fmsp_pkg::*;

  logic take;
  logic push;
  evt_t front_evt;
  logic q_full;
  logic q_pop;
  logic q_valid;
  evt_t q_evt;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  fmsp_front #(
    .NAME_BYTES        (NAME_BYTES),
    .LENGTH_CODE_BYTES (LENGTH_CODE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .byte_in   (in_byte),
    .evt_valid (push),
    .evt       (front_evt)
  );

  fmsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_evt  (front_evt),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_evt   (q_evt)
  );

  fmsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_evt          (q_evt),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_code_byte  (out_code_byte),
    .out_message_id (out_message_id),
    .out_sync_flags (out_sync_flags),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_error_code (out_error_code)
  );

endmodule

@@ hw/rtl/fmsp_front.sv @@
// Front end: configuration registers and the byte-level message parser.
// Produces at most one event per accepted byte. Depends on fmsp_pkg.
`timescale 1ns / 1ps

module fmsp_front #(
  parameter int NAME_BYTES        = 6,
  parameter int LENGTH_CODE_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [fmsp_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                           take,
  input  logic [7:0]                     byte_in,
  output logic                           evt_valid,
  output fmsp_pkg::evt_t                 evt
);
  import fmsp_pkg::*;

  localparam int HDR_LEN = 6 + NAME_BYTES;

  logic [47:0] exp_name_r;
  logic [7:0]  exp_version_r;
  logic [7:0]  flag_mask_r;
  logic [3:0]  ack_code_r;
  logic [3:0]  disc_code_r;
  logic [3:0]  ping_code_r;
  logic [3:0]  sync_code_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [27:0] len_total_r, len_total_nxt;
  logic [1:0]  len_seen_r, len_seen_nxt;
  logic [27:0] pay_seen_r, pay_seen_nxt;
  logic [7:0]  held_code_r, held_code_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] held_id_r, held_id_nxt;
  logic [7:0]  held_flags_r, held_flags_nxt;

  logic [27:0] len_add;
  logic [27:0] len_sum;
  logic        len_too_long;
  logic [27:0] pay_inc;
  logic        pay_end;
  logic        is_ack, is_disc, is_ping, is_sync;
  logic        hdr_pos;
  logic [3:0]  hp;
  logic [7:0]  name_exp;
  logic [7:0]  code_eff;
  logic        fin_valid;
  evt_t        fin_evt;
  logic        evt_raw_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_name_r    <= '0;
      exp_version_r <= 8'd1;
      flag_mask_r   <= 8'd1;
      ack_code_r    <= 4'd2;
      disc_code_r   <= 4'd14;
      ping_code_r   <= 4'd13;
      sync_code_r   <= 4'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXP_NAME:    exp_name_r    <= cfg_data[47:0];
        REG_EXP_VERSION: exp_version_r <= cfg_data[7:0];
        REG_FLAG_MASK:   flag_mask_r   <= cfg_data[7:0];
        REG_ACK_CODE:    ack_code_r    <= cfg_data[3:0];
        REG_DISC_CODE:   disc_code_r   <= cfg_data[3:0];
        REG_PING_CODE:   ping_code_r   <= cfg_data[3:0];
        REG_SYNC_CODE:   sync_code_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The length code carries seven value bits per byte, least significant first.
  always_comb begin
    unique case (len_seen_r)
      2'd0:    len_add = {21'b0, byte_in[6:0]};
      2'd1:    len_add = {14'b0, byte_in[6:0], 7'b0};
      2'd2:    len_add = {7'b0, byte_in[6:0], 14'b0};
      default: len_add = {byte_in[6:0], 21'b0};
    endcase
  end

  assign len_sum      = len_total_r + len_add;
  assign len_too_long = ({1'b0, len_seen_r} + 3'd1) >= 3'(LENGTH_CODE_BYTES);
  assign pay_inc      = pay_seen_r + 28'd1;
  assign pay_end      = (pay_inc == len_total_r);

  assign is_ack  = (type_r == ack_code_r);
  assign is_disc = (type_r == disc_code_r);
  assign is_ping = (type_r == ping_code_r);
  assign is_sync = (type_r == sync_code_r);

  assign hdr_pos = (pay_seen_r < 28'(HDR_LEN));
  assign hp      = pay_seen_r[3:0];

  always_comb begin
    name_exp = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (hp == 4'(i + 2)) begin
        name_exp = exp_name_r[8*(NAME_BYTES-1-i) +: 8];
      end
    end
  end

  // Payload byte one becomes the code, also when it is the final byte.
  assign code_eff = (pay_seen_r == 28'd1) ? byte_in : held_code_r;

  // End of a complete message; type priority is ack, disconnect, ping, sync.
  always_comb begin
    fin_evt   = '0;
    fin_valid = 1'b1;
    priority if (is_ack) begin
      fin_evt.kind = EVT_ACK;
      fin_evt.code = code_eff;
    end else if (is_disc) begin
      fin_evt.kind = EVT_DISCONNECT;
      fin_evt.code = code_eff;
    end else if (is_ping) begin
      fin_evt.kind = EVT_PING;
    end else if (is_sync) begin
      fin_evt.kind = EVT_ERROR;
      fin_evt.err  = ERR_SYNC_SHORT;
    end else begin
      fin_valid = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_LENGTH: begin
        if (byte_in[7]) begin
          phase_nxt = len_too_long ? PH_IDLE : PH_LENGTH;
        end else begin
          phase_nxt = (len_sum == 28'd0) ? PH_IDLE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: phase_nxt = pay_end ? PH_IDLE : PH_PAYLOAD;
      default:    phase_nxt = PH_LENGTH;
    endcase
  end

  always_comb begin
    type_nxt       = type_r;
    len_total_nxt  = len_total_r;
    len_seen_nxt   = len_seen_r;
    pay_seen_nxt   = pay_seen_r;
    held_code_nxt  = held_code_r;
    hdr_ok_nxt     = hdr_ok_r;
    held_id_nxt    = held_id_r;
    held_flags_nxt = held_flags_r;
    evt            = '0;
    evt_raw_valid  = 1'b0;
    unique case (phase_r)
      PH_LENGTH: begin
        len_total_nxt = len_sum;
        if (byte_in[7]) begin
          if (len_too_long) begin
            evt_raw_valid = 1'b1;
            evt.kind      = EVT_ERROR;
            evt.err       = ERR_LEN_LONG;
          end else begin
            len_seen_nxt = len_seen_r + 2'd1;
          end
        end else if (len_sum == 28'd0) begin
          evt_raw_valid = fin_valid;
          evt           = fin_evt;
        end
      end
      PH_PAYLOAD: begin
        pay_seen_nxt = pay_inc;
        if (is_ack || is_disc || is_ping) begin
          if (pay_seen_r == 28'd1) begin
            held_code_nxt = byte_in;
          end
          if (pay_end) begin
            evt_raw_valid = fin_valid;
            evt           = fin_evt;
          end
        end else if (is_sync) begin
          if (hdr_pos) begin
            priority if (hp == 4'd0) begin
              if (byte_in != 8'(NAME_BYTES >> 8)) hdr_ok_nxt = 1'b0;
            end else if (hp == 4'd1) begin
              if (byte_in != 8'(NAME_BYTES)) hdr_ok_nxt = 1'b0;
            end else if (hp < 4'(2 + NAME_BYTES)) begin
              if (byte_in != name_exp) hdr_ok_nxt = 1'b0;
            end else if (hp == 4'(2 + NAME_BYTES)) begin
              if (byte_in != exp_version_r) hdr_ok_nxt = 1'b0;
            end else if (hp == 4'(3 + NAME_BYTES)) begin
              held_id_nxt = {byte_in, 8'h00};
            end else if (hp == 4'(4 + NAME_BYTES)) begin
              held_id_nxt = {held_id_r[15:8], byte_in};
            end else begin
              held_flags_nxt = byte_in;
            end
            if (hp == 4'(HDR_LEN - 1)) begin
              if (!hdr_ok_r) begin
                evt_raw_valid = 1'b1;
                evt.kind      = EVT_ERROR;
                evt.err       = ERR_BAD_HEADER;
              end else if ((byte_in & flag_mask_r) != 8'd0) begin
                evt_raw_valid = 1'b1;
                evt.kind      = EVT_SYNC_HDR;
                evt.id        = held_id_r;
                evt.flags     = byte_in;
                evt.last      = pay_end;
              end
            end else if (pay_end) begin
              evt_raw_valid = 1'b1;
              evt.kind      = EVT_ERROR;
              evt.err       = ERR_SYNC_SHORT;
            end
          end else if (hdr_ok_r && ((held_flags_r & flag_mask_r) != 8'd0)) begin
            evt_raw_valid = 1'b1;
            evt.kind      = EVT_SYNC_DATA;
            evt.id        = held_id_r;
            evt.flags     = held_flags_r;
            evt.data      = byte_in;
            evt.last      = pay_end;
          end
        end
      end
      default: begin
        // Type byte: a new message starts and all per-message state clears.
        type_nxt       = byte_in[7:4];
        len_total_nxt  = '0;
        len_seen_nxt   = '0;
        pay_seen_nxt   = '0;
        held_code_nxt  = '0;
        hdr_ok_nxt     = 1'b1;
        held_id_nxt    = '0;
        held_flags_nxt = '0;
      end
    endcase
  end

  assign evt_valid = take && evt_raw_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      type_r       <= '0;
      len_total_r  <= '0;
      len_seen_r   <= '0;
      pay_seen_r   <= '0;
      held_code_r  <= '0;
      hdr_ok_r     <= 1'b1;
      held_id_r    <= '0;
      held_flags_r <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      len_total_r  <= len_total_nxt;
      len_seen_r   <= len_seen_nxt;
      pay_seen_r   <= pay_seen_nxt;
      held_code_r  <= held_code_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      held_id_r    <= held_id_nxt;
      held_flags_r <= held_flags_nxt;
    end
  end

endmodule

@@ hw/rtl/fmsp_queue.sv @@
// Small event queue that decouples the parser from the output stage.
// Depends on fmsp_pkg for the event record and the depth.
`timescale 1ns / 1ps

module fmsp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fmsp_pkg::evt_t push_evt,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output fmsp_pkg::evt_t pop_evt
);
  import fmsp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_evt   = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/fmsp_back.sv @@
// Back end: output register that presents one event as separate result fields.
// Depends on fmsp_pkg for the event record.
`timescale 1ns / 1ps

module fmsp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fmsp_pkg::evt_t q_evt,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_event_kind,
  output logic [7:0]     out_code_byte,
  output logic [15:0]    out_message_id,
  output logic [7:0]     out_sync_flags,
  output logic [7:0]     out_data_byte,
  output logic           out_last,
  output logic [1:0]     out_error_code
);
  import fmsp_pkg::*;

  logic valid_r, valid_nxt;
  evt_t evt_r;
  logic load;

  // The register refills in the same cycle its transfer completes.
  assign load      = !valid_r || out_ready;
  assign q_pop     = load && q_valid;
  assign valid_nxt = load ? q_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      evt_r <= q_evt;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_kind = evt_r.kind;
  assign out_code_byte  = evt_r.code;
  assign out_message_id = evt_r.id;
  assign out_sync_flags = evt_r.flags;
  assign out_data_byte  = evt_r.data;
  assign out_last       = evt_r.last;
  assign out_error_code = evt_r.err;

endmodule

@@ hw/rtl/fmsp_checker.sv @@
// Port-level checker for the framed message stream parser, bound to the top level.
// Depends on fmsp_pkg and framed_message_stream_parser_top_assert.svh.
`timescale 1ns / 1ps
`include "framed_message_stream_parser_top_assert.svh"

module fmsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_kind,
  input logic [7:0]  out_code_byte,
  input logic [15:0] out_message_id,
  input logic [7:0]  out_sync_flags,
  input logic [7:0]  out_data_byte,
  input logic        out_last,
  input logic [1:0]  out_error_code
);
  import fmsp_pkg::*;

  // A stalled result keeps its valid, kind, id, data byte and last mark until the transfer.
  `FMSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_event_kind) && $stable(out_message_id) && $stable(out_data_byte) && $stable(out_last))

  // Only sync events carry an id and flags.
  `FMSP_ASSERT_IMPL(a_sync_fields, clk, rst_n, out_valid && out_event_kind != EVT_SYNC_HDR && out_event_kind != EVT_SYNC_DATA, out_message_id == 16'd0 && out_sync_flags == 8'd0 && out_data_byte == 8'd0)

  // The last mark belongs to sync header or sync data events.
  `FMSP_ASSERT_IMPL(a_last_sync, clk, rst_n, out_valid && out_last, out_event_kind == EVT_SYNC_HDR || out_event_kind == EVT_SYNC_DATA)

  // Error codes appear on error events only, and codes only on ack or disconnect.
  `FMSP_ASSERT_IMPL(a_err_kind, clk, rst_n, out_valid && out_event_kind != EVT_ERROR, out_error_code == ERR_BAD_HEADER)
  `FMSP_ASSERT_IMPL(a_code_kind, clk, rst_n, out_valid && out_event_kind != EVT_ACK && out_event_kind != EVT_DISCONNECT, out_code_byte == 8'd0)

endmodule

bind framed_message_stream_parser_top fmsp_checker u_fmsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_kind (out_event_kind),
  .out_code_byte  (out_code_byte),
  .out_message_id (out_message_id),
  .out_sync_flags (out_sync_flags),
  .out_data_byte  (out_data_byte),
  .out_last       (out_last),
  .out_error_code (out_error_code)
);
